/* design/pdpt_pkg.sv */
// package for the prefix table block: item types, command and status codes,
// controller-to-datapath command struct. no dependencies
package pdpt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 16;
  localparam int unsigned KEY_BYTES_DEF   = 7;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned KEY_W    = 56;
  localparam int unsigned HND_W    = 4;
  localparam int unsigned TAG_W    = 32;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ARM    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DISARM = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [HND_W-1:0] handler_id;
    logic [TAG_W-1:0] aux_tag;
  } in_item_t;

  typedef struct packed {
    logic                hit;
    logic [SLOT_W-1:0]   slot;
    logic [HND_W-1:0]    found_handler;
    logic [TAG_W-1:0]    found_tag;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_t;

endpackage

/* design/packet_demux_prefix_table_core.sv */
// top level of the packet demux prefix table: controller plus cell datapath
// depends on pdpt_pkg, pdpt_ctrl, pdpt_datapath
//
// Associative table of up to TABLE_DEPTH entries, each a KEY_BYTES-byte prefix
// key with a 4-bit handler number and a 32-bit tag, kept in insertion order.
// Input channel (in_valid_i / in_ready_o / in_item_i) carries one command:
// lookup, arm (overwrite or append) or disarm (remove and close the gap).
// Output channel (out_valid_o / out_ready_i / out_item_o) returns exactly one
// result item per command: hit, slot, found handler and tag, and status.
// The key is compared against all cells in the accept cycle and the match
// vector registered; the table update and result register follow in the
// execute step. A new item is accepted only after that update, since the
// compare-then-update sequence runs over the single cell row.
// A finished result sits in the output register while the next item is
// accepted and compared; that item's update waits only if the previous
// result has still not been taken.
// Reset empties the table at once (entry count to zero); cell contents are
// not cleared and are never read before being written.
module packet_demux_prefix_table_core #(
  parameter int unsigned TABLE_DEPTH = pdpt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BYTES   = pdpt_pkg::KEY_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pdpt_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pdpt_pkg::out_item_t out_item_o
);
  import pdpt_pkg::*;

  ctrl_t ctrl;

  pdpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctrl_o      (ctrl)
  );

  pdpt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("item accepted while previous command still in progress");

  a_hit_means_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.hit |-> out_item_o.status == STATUS_OK)
    else $error("hit reported with non-ok status");

  a_fail_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status != STATUS_OK) |->
      (out_item_o.slot == '0) && (out_item_o.found_tag == '0) && !out_item_o.hit)
    else $error("failed command returned nonzero fields");

endmodule

/* design/pdpt_ctrl.sv */
// controller for the prefix table block: accepts an item, then runs the
// table update and loads the output register. depends on pdpt_pkg
module pdpt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output pdpt_pkg::ctrl_t ctrl_o
);
  import pdpt_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   capture;
  logic   execute;

  assign capture = (state_q == ST_IDLE) && in_valid_i;
  assign execute = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (capture) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (execute) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (execute) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign ctrl_o.capture = capture;
  assign ctrl_o.execute = execute;

endmodule

/* design/pdpt_datapath.sv */
// datapath for the prefix table block: row of key cells with parallel compare,
// first-match select, in-place write, append and shift-down removal.
// depends on pdpt_pkg
module pdpt_datapath #(
  parameter int unsigned TABLE_DEPTH = pdpt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BYTES   = pdpt_pkg::KEY_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pdpt_pkg::ctrl_t     ctrl_i,
  input  pdpt_pkg::in_item_t  in_item_i,
  output pdpt_pkg::out_item_t out_item_o
);
  import pdpt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KeyW = (8 * KEY_BYTES < KEY_W) ? 8 * KEY_BYTES : KEY_W;

  // table cells
  logic [KeyW-1:0]  key_q [TABLE_DEPTH];
  logic [HND_W-1:0] hnd_q [TABLE_DEPTH];
  logic [TAG_W-1:0] tag_q [TABLE_DEPTH];
  logic [CntW-1:0]  count_q;

  // captured item
  logic [CMD_W-1:0]       cmd_q;
  logic [KeyW-1:0]        ikey_q;
  logic [HND_W-1:0]       ihnd_q;
  logic [TAG_W-1:0]       itag_q;
  logic [TABLE_DEPTH-1:0] match_q;
  logic [TABLE_DEPTH-1:0] match_d;

  out_item_t out_q;
  out_item_t res_d;

  logic [KeyW-1:0]        in_key;
  logic [TABLE_DEPTH-1:0] first_oh;
  logic [TABLE_DEPTH-1:0] shift_mask;
  logic [TABLE_DEPTH-1:0] wr_oh;
  logic                   hit;
  logic                   full;
  logic [IdxW-1:0]        idx;
  logic [HND_W-1:0]       sel_hnd;
  logic [TAG_W-1:0]       sel_tag;
  logic [IdxW+SLOT_W-1:0] idx_ext;
  logic [CntW+SLOT_W-1:0] cnt_ext;
  logic                   arm_we;
  logic                   dis_en;

  assign in_key = in_item_i.key[KeyW-1:0];

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_d[i] = (CntW'(i) < count_q) && (key_q[i] == in_key);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= in_item_i.cmd;
      ikey_q  <= in_key;
      ihnd_q  <= in_item_i.handler_id;
      itag_q  <= in_item_i.aux_tag;
      match_q <= match_d;
    end
  end

  // first match and its contents
  assign first_oh   = match_q & (~match_q + TABLE_DEPTH'(1));
  assign shift_mask = ~(first_oh - TABLE_DEPTH'(1));
  assign hit        = |match_q;
  assign full       = (count_q == CntW'(TABLE_DEPTH));

  always_comb begin
    idx     = '0;
    sel_hnd = '0;
    sel_tag = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (first_oh[i]) begin
        idx     = idx | IdxW'(i);
        sel_hnd = sel_hnd | hnd_q[i];
        sel_tag = sel_tag | tag_q[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      wr_oh[i] = hit ? first_oh[i] : (count_q == CntW'(i));
    end
  end

  assign arm_we = ctrl_i.execute && (cmd_q == CMD_ARM) && (hit || !full);
  assign dis_en = ctrl_i.execute && (cmd_q == CMD_DISARM) && hit;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g < TABLE_DEPTH - 1) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (arm_we && wr_oh[g]) begin
          key_q[g] <= ikey_q;
          hnd_q[g] <= ihnd_q;
          tag_q[g] <= itag_q;
        end else if (dis_en && shift_mask[g]) begin
          key_q[g] <= key_q[g+1];
          hnd_q[g] <= hnd_q[g+1];
          tag_q[g] <= tag_q[g+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (arm_we && wr_oh[g]) begin
          key_q[g] <= ikey_q;
          hnd_q[g] <= ihnd_q;
          tag_q[g] <= itag_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (arm_we && !hit) begin
      count_q <= count_q + CntW'(1);
    end else if (dis_en) begin
      count_q <= count_q - CntW'(1);
    end
  end

  // result
  assign idx_ext = {{SLOT_W{1'b0}}, idx};
  assign cnt_ext = {{SLOT_W{1'b0}}, count_q};

  always_comb begin
    res_d               = '0;
    res_d.hit           = hit;
    unique case (cmd_q)
      CMD_ARM: begin
        if (hit) begin
          res_d.slot = idx_ext[SLOT_W-1:0];
        end else if (full) begin
          res_d.status = STATUS_FULL;
        end else begin
          res_d.slot = cnt_ext[SLOT_W-1:0];
        end
      end
      CMD_DISARM: begin
        if (hit) begin
          res_d.slot = idx_ext[SLOT_W-1:0];
        end else begin
          res_d.status = STATUS_ABSENT;
        end
      end
      default: begin
        if (hit) begin
          res_d.slot          = idx_ext[SLOT_W-1:0];
          res_d.found_handler = sel_hnd;
          res_d.found_tag     = sel_tag;
        end else begin
          res_d.status = STATUS_ABSENT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute) begin
      out_q <= res_d;
    end
  end

  assign out_item_o = out_q;

endmodule

/* tb/sv/packet_demux_prefix_table_core_test.sv */
// testbench for packet_demux_prefix_table_core: drives table commands with random
// gaps and stalls, predicts each result from a local copy of the table and checks it
// depends on pdpt_pkg and packet_demux_prefix_table_core
`timescale 1ns / 1ps

module packet_demux_prefix_table_core_test;
  import pdpt_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - 8 * KEY_BYTES_DEF);
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam int POOL_SIZE = 20;
  localparam int STUCK_LIMIT = 400;

  logic      clk_i;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  logic [KEY_W-1:0] tbl_key [DEPTH];
  logic [HND_W-1:0] tbl_handler [DEPTH];
  logic [TAG_W-1:0] tbl_tag [DEPTH];
  int               tbl_count = 0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  out_item_t        pending_results[$];
  int               errors = 0;
  int               stuck = 0;
  int               sink_hold = 0;
  bit               src_idle = 1'b0;
  bit               sink_idle = 1'b0;

  packet_demux_prefix_table_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // expected result of one command, updates the local table
  function automatic out_item_t run_table_cmd(input in_item_t it);
    out_item_t        r;
    logic [KEY_W-1:0] k;
    int               idx;
    int               i;
    r = '0;
    k = it.key & KEY_MASK;
    idx = -1;
    for (i = tbl_count - 1; i >= 0; i--) begin
      if (tbl_key[i] == k) idx = i;
    end
    case (it.cmd)
      CMD_ARM: begin
        if (idx >= 0) begin
          r.hit = 1'b1;
        end else if (tbl_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          idx = tbl_count;
          tbl_count++;
        end
        if (r.status == STATUS_OK) begin
          tbl_key[idx] = k;
          tbl_handler[idx] = it.handler_id;
          tbl_tag[idx] = it.aux_tag;
          r.slot = idx[SLOT_W-1:0];
        end
      end
      CMD_DISARM: begin
        if (idx >= 0) begin
          r.hit = 1'b1;
          r.slot = idx[SLOT_W-1:0];
          for (i = idx; i + 1 < tbl_count; i++) begin
            tbl_key[i] = tbl_key[i+1];
            tbl_handler[i] = tbl_handler[i+1];
            tbl_tag[i] = tbl_tag[i+1];
          end
          tbl_count--;
        end else begin
          r.status = STATUS_ABSENT;
        end
      end
      default: begin
        if (idx >= 0) begin
          r.hit = 1'b1;
          r.slot = idx[SLOT_W-1:0];
          r.found_handler = tbl_handler[idx];
          r.found_tag = tbl_tag[idx];
        end else begin
          r.status = STATUS_ABSENT;
        end
      end
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    errors++;
    if (errors <= 30) $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_item_t want;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with no item pending", 64'd0, 64'(out_item));
      end else begin
        want = pending_results.pop_front();
        if (out_item.hit !== want.hit)
          note_mismatch("hit", 64'(want.hit), 64'(out_item.hit));
        if (out_item.slot !== want.slot)
          note_mismatch("slot", 64'(want.slot), 64'(out_item.slot));
        if (out_item.found_handler !== want.found_handler)
          note_mismatch("found_handler", 64'(want.found_handler),
                        64'(out_item.found_handler));
        if (out_item.found_tag !== want.found_tag)
          note_mismatch("found_tag", 64'(want.found_tag), 64'(out_item.found_tag));
        if (out_item.status !== want.status)
          note_mismatch("status", 64'(want.status), 64'(out_item.status));
      end
    end
  end

  // output stalls
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      out_ready = 1'b0;
      sink_hold--;
    end else if (sink_idle && $urandom_range(0, 3) == 0) begin
      out_ready = 1'b0;
      sink_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(3, 19);
    end else begin
      out_ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck = 0;
    end else begin
      stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("packet_demux_prefix_table_core: mismatch");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!src_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[KEY_W-1:0];
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_item(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_item = it;
    in_valid = 1'b1;
    do @(posedge clk_i); while (!in_ready);
    pending_results.push_back(run_table_cmd(it));
    @(negedge clk_i);
  endtask

  task automatic release_input();
    in_valid = 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [KEY_W-1:0] k,
                          input logic [HND_W-1:0] h, input logic [TAG_W-1:0] t);
    in_item_t it;
    it.cmd = c;
    it.key = k;
    it.handler_id = h;
    it.aux_tag = t;
    send_item(it);
  endtask

  task automatic refill_key_pool();
    int i;
    key_pool[0] = '0;
    key_pool[1] = KEY_MASK;
    for (i = 2; i < POOL_SIZE; i++) key_pool[i] = random_key();
    // near misses differ from another key in a single bit
    for (i = 14; i < POOL_SIZE; i++)
      key_pool[i] = key_pool[i-12] ^ (56'd1 << $urandom_range(0, KEY_W - 1));
  endtask

  function automatic in_item_t random_cmd(input int p_lookup, input int p_arm,
                                          input int p_disarm);
    in_item_t it;
    int       r;
    r = $urandom_range(0, 99);
    if (r < p_lookup) it.cmd = CMD_LOOKUP;
    else if (r < p_lookup + p_arm) it.cmd = CMD_ARM;
    else if (r < p_lookup + p_arm + p_disarm) it.cmd = CMD_DISARM;
    else it.cmd = CMD_SPARE;
    it.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                          : random_key();
    it.handler_id = HND_W'($urandom_range(0, 15));
    it.aux_tag = $urandom();
    return it;
  endfunction

  task automatic test_directed();
    logic [KEY_W-1:0] ka;
    ka = 56'h5a_a5c3_3c96_690f & KEY_MASK;
    send_cmd(CMD_LOOKUP, '0, 4'h0, 32'h0);
    send_cmd(CMD_DISARM, KEY_MASK, 4'hf, 32'hffff_ffff);
    send_cmd(CMD_ARM, '0, 4'h0, 32'h0);
    send_cmd(CMD_ARM, KEY_MASK, 4'hf, 32'hffff_ffff);
    send_cmd(CMD_LOOKUP, KEY_MASK, 4'h0, 32'h0);
    send_cmd(CMD_SPARE, '0, 4'h3, 32'h1);
    send_cmd(CMD_ARM, '0, 4'h9, 32'h5a5a_a5a5);
    send_cmd(CMD_ARM, ka, 4'h5, 32'h1234_5678);
    send_cmd(CMD_LOOKUP, '0, 4'h0, 32'h0);
    send_cmd(CMD_DISARM, '0, 4'h0, 32'h0);
    send_cmd(CMD_LOOKUP, KEY_MASK, 4'h0, 32'h0);
    send_cmd(CMD_LOOKUP, ka, 4'h0, 32'h0);
    send_cmd(CMD_DISARM, KEY_MASK, 4'h0, 32'h0);
    send_cmd(CMD_LOOKUP, KEY_MASK, 4'h0, 32'h0);
    send_cmd(CMD_DISARM, ka, 4'h0, 32'h0);
    send_cmd(CMD_DISARM, ka, 4'h0, 32'h0);
    send_cmd(CMD_SPARE, ka, 4'h0, 32'h0);
  endtask

  // fill every slot, arm on a full table, then empty it in random order
  task automatic test_table_full();
    logic [KEY_W-1:0] keys [DEPTH];
    int               i;
    for (i = 0; i < DEPTH; i++) begin
      keys[i] = random_key();
      send_cmd(CMD_ARM, keys[i], HND_W'($urandom_range(0, 15)), $urandom());
    end
    send_cmd(CMD_ARM, random_key(), 4'h7, 32'h7777_0000);
    send_cmd(CMD_ARM, keys[DEPTH-1], 4'h1, 32'h0000_7777);
    send_cmd(CMD_LOOKUP, keys[DEPTH-1], 4'h0, 32'h0);
    send_cmd(CMD_DISARM, keys[0], 4'h0, 32'h0);
    send_cmd(CMD_ARM, keys[0], 4'h2, 32'h2222_2222);
    send_cmd(CMD_LOOKUP, keys[0], 4'h0, 32'h0);
    keys.shuffle();
    for (i = 0; i < DEPTH; i++) send_cmd(CMD_DISARM, keys[i], 4'h0, 32'h0);
  endtask

  task automatic test_random_churn(input int n);
    int i;
    refill_key_pool();
    for (i = 0; i < n; i++) send_item(random_cmd(40, 35, 20));
  endtask

  // arm-heavy runs push the table to full, disarm-heavy runs drain it
  task automatic test_fill_drain(input int rounds);
    int i;
    int j;
    for (j = 0; j < rounds; j++) begin
      refill_key_pool();
      for (i = 0; i < 60; i++) send_item(random_cmd(20, 70, 8));
      for (i = 0; i < 40; i++) send_item(random_cmd(20, 10, 68));
    end
  endtask

  task automatic test_back_to_back(input int n);
    int i;
    src_idle = 1'b0;
    sink_idle = 1'b0;
    refill_key_pool();
    for (i = 0; i < n; i++) send_item(random_cmd(35, 35, 25));
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  // after every tenth item the sender holds off until every pending result is back
  task automatic test_drain_pause(input int n);
    int i;
    refill_key_pool();
    for (i = 0; i < n; i++) begin
      send_item(random_cmd(40, 35, 20));
      if (i % 10 == 9) begin
        release_input();
        while (pending_results.size() != 0) @(posedge clk_i);
        @(negedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    src_idle = 1'b1;
    sink_idle = 1'b1;
    test_directed();
    test_table_full();
    test_random_churn(450);
    test_back_to_back(150);
    test_fill_drain(4);
    test_drain_pause(100);
    release_input();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("packet_demux_prefix_table_core: match");
    end else begin
      $display("packet_demux_prefix_table_core: mismatch");
    end
    $finish;
  end

endmodule
